// File: src/pcbs_pkg.sv
`default_nettype none

package pcbs_pkg;

    localparam int unsigned REG_W     = 16;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned FAULT_W   = 7;

    // numerator is (sample - rest) * 100, or sample * 100 without calibration, below 4096 * 100
    localparam int unsigned REM_W     = 19;
    localparam int unsigned QUOT_W    = PCT_W;
    localparam int unsigned TRIAL_W   = REG_W + QUOT_W;
    localparam int unsigned STEP_PER  = 2;
    localparam int unsigned DIV_STAGES = (QUOT_W + STEP_PER - 1) / STEP_PER;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [IDX_W-1:0] REG_T1_REST    = 4'd0;
    localparam logic [IDX_W-1:0] REG_T1_FULL    = 4'd1;
    localparam logic [IDX_W-1:0] REG_T2_REST    = 4'd2;
    localparam logic [IDX_W-1:0] REG_T2_FULL    = 4'd3;
    localparam logic [IDX_W-1:0] REG_BRAKE_REST = 4'd4;
    localparam logic [IDX_W-1:0] REG_BRAKE_ARM  = 4'd5;
    localparam logic [IDX_W-1:0] REG_BRAKE_HARD = 4'd6;
    localparam logic [IDX_W-1:0] REG_BRAKE_FULL = 4'd7;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_ZERO = 2'd1;
    localparam logic [1:0] CLAMP_FULL = 2'd2;

    localparam int unsigned F_RANGE     = 0;
    localparam int unsigned F_MONO      = 1;
    localparam int unsigned F_SPAN1     = 2;
    localparam int unsigned F_SPAN2     = 3;
    localparam int unsigned F_RATIO     = 4;
    localparam int unsigned F_BRK_SPAN  = 5;
    localparam int unsigned F_BRK_ORDER = 6;

    typedef struct packed {
        logic                used;
        logic [1:0]          clamp;
        logic [SAMPLE_W-1:0] num;
        logic [REG_W-1:0]    den;
    } pre_t;

    typedef struct packed {
        logic              used;
        logic [1:0]        clamp;
        logic [REG_W-1:0]  den;
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
    } div_t;

endpackage

`default_nettype wire

// File: src/pedal_calibration_check_and_brake_scale.sv
`default_nettype none

// Pedal calibration check and brake scaling. One brake sample is taken per
// cycle (busy is always low); each sample yields one result word through the
// stages below, marked by done for a single cycle, with no way to hold it
// off. The path is an input stage, a x100 multiply stage, and a four-stage
// restoring divider retiring up to two quotient bits per stage, plus the
// output register. fault_bits follows the calibration registers through the
// span, ratio-product and fault-word registers after a write and is independent of the sample.
module pedal_calibration_check_and_brake_scale #(
    parameter int unsigned ADC_FULL           = 4095,
    parameter int unsigned MIN_THROTTLE_SPAN  = 200,
    parameter int unsigned MAX_SPAN_RATIO_PCT = 150,
    parameter int unsigned MIN_BRAKE_SPAN     = 100
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [pcbs_pkg::SAMPLE_W-1:0]  brake_sample,
    input  wire logic                           cfg_wr_en,
    input  wire logic [pcbs_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [pcbs_pkg::REG_W-1:0]     cfg_wr_data,
    output logic                                done,
    output logic [pcbs_pkg::PCT_W-1:0]          brake_percent,
    output logic [pcbs_pkg::FAULT_W-1:0]        fault_bits,
    output logic                                used_calibration
);
    import pcbs_pkg::*;

    localparam int unsigned RATIO_W  = $clog2(MAX_SPAN_RATIO_PCT + 1);
    localparam int unsigned MULT_W   = (RATIO_W > PCT_W) ? RATIO_W : PCT_W;
    localparam int unsigned PROD_W   = REG_W + MULT_W;

    localparam logic [REG_W-1:0]  ADC_FULL_V  = REG_W'(ADC_FULL);
    localparam logic [REG_W-1:0]  MIN_TS_V    = REG_W'(MIN_THROTTLE_SPAN);
    localparam logic [REG_W-1:0]  MIN_BS_V    = REG_W'(MIN_BRAKE_SPAN);
    localparam logic [MULT_W-1:0] RATIO_V     = MULT_W'(MAX_SPAN_RATIO_PCT);
    localparam logic [MULT_W-1:0] HUNDRED_V   = MULT_W'(100);

    // calibration registers
    logic [REG_W-1:0] cfg_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en && (cfg_index < IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_wr_data;
        end
    end

    logic [REG_W-1:0] t1_rest, t1_full, t2_rest, t2_full;
    logic [REG_W-1:0] b_rest, b_arm, b_hard, b_full;

    assign t1_rest = cfg_reg[REG_T1_REST[2:0]];
    assign t1_full = cfg_reg[REG_T1_FULL[2:0]];
    assign t2_rest = cfg_reg[REG_T2_REST[2:0]];
    assign t2_full = cfg_reg[REG_T2_FULL[2:0]];
    assign b_rest  = cfg_reg[REG_BRAKE_REST[2:0]];
    assign b_arm   = cfg_reg[REG_BRAKE_ARM[2:0]];
    assign b_hard  = cfg_reg[REG_BRAKE_HARD[2:0]];
    assign b_full  = cfg_reg[REG_BRAKE_FULL[2:0]];

    // fault pipeline, stage 1: spans and plain compares
    logic [REG_W-1:0] span1_reg, span2_reg;
    logic             range_reg, mono_reg, brk_span_reg, brk_order_reg;
    logic [REG_W-1:0] span1_next, span2_next, brk_span;
    logic             range_next;

    always_comb
    begin
        span1_next = (t1_full > t1_rest) ? (t1_full - t1_rest) : '0;
        span2_next = (t2_full > t2_rest) ? (t2_full - t2_rest) : '0;
        brk_span   = (b_full > b_rest) ? (b_full - b_rest) : '0;
        range_next = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (cfg_reg[i] > ADC_FULL_V)
            begin
                range_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        span1_reg     <= span1_next;
        span2_reg     <= span2_next;
        range_reg     <= range_next;
        mono_reg      <= (t1_full <= t1_rest) || (t2_full <= t2_rest);
        brk_span_reg  <= (b_rest != '0) && (brk_span < MIN_BS_V);
        brk_order_reg <= !((b_arm < b_hard) && (b_hard < b_full))
                         || ((b_rest != '0) && (b_rest >= b_arm));
    end

    // fault pipeline, stage 2: ratio products
    logic [PROD_W-1:0] small_prod_reg, big_prod_reg;
    logic              s1_small_reg, s2_small_reg;
    logic              range2_reg, mono2_reg, brk_span2_reg, brk_order2_reg;
    logic [REG_W-1:0]  span_big, span_small;

    assign span_big   = (span1_reg > span2_reg) ? span1_reg : span2_reg;
    assign span_small = (span1_reg > span2_reg) ? span2_reg : span1_reg;

    always_ff @(posedge clk)
    begin
        small_prod_reg <= PROD_W'(span_small) * PROD_W'(RATIO_V);
        big_prod_reg   <= PROD_W'(span_big) * PROD_W'(HUNDRED_V);
        s1_small_reg   <= span1_reg < MIN_TS_V;
        s2_small_reg   <= span2_reg < MIN_TS_V;
        range2_reg     <= range_reg;
        mono2_reg      <= mono_reg;
        brk_span2_reg  <= brk_span_reg;
        brk_order2_reg <= brk_order_reg;
    end

    // fault pipeline, stage 3: fault word
    logic [FAULT_W-1:0] fault_reg, fault_next;

    always_comb
    begin
        fault_next              = '0;
        fault_next[F_RANGE]     = range2_reg;
        fault_next[F_MONO]      = mono2_reg;
        fault_next[F_SPAN1]     = s1_small_reg;
        fault_next[F_SPAN2]     = s2_small_reg;
        fault_next[F_RATIO]     = !s1_small_reg && !s2_small_reg
                                  && (small_prod_reg < big_prod_reg);
        fault_next[F_BRK_SPAN]  = brk_span2_reg;
        fault_next[F_BRK_ORDER] = brk_order2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg <= '0;
        end
        else
        begin
            fault_reg <= fault_next;
        end
    end

    // sample pipeline, input stage: pick map, clamp, numerator and divisor
    logic       accept;
    logic       pre_vld_reg;
    pre_t       pre_reg, pre_next;
    logic [REG_W-1:0] raw_ext;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign raw_ext = REG_W'(brake_sample);

    always_comb
    begin
        pre_next.used  = (b_rest != '0) && (b_full > b_rest);
        pre_next.clamp = CLAMP_NONE;
        if (pre_next.used)
        begin
            pre_next.num = SAMPLE_W'(raw_ext - b_rest);
            pre_next.den = b_full - b_rest;
            if (raw_ext <= b_rest)
            begin
                pre_next.clamp = CLAMP_ZERO;
            end
            else if (raw_ext >= b_full)
            begin
                pre_next.clamp = CLAMP_FULL;
            end
        end
        else
        begin
            pre_next.num = brake_sample;
            pre_next.den = ADC_FULL_V;
            if (raw_ext >= ADC_FULL_V)
            begin
                pre_next.clamp = CLAMP_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
        end
        else
        begin
            pre_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg <= pre_next;
    end

    // multiply stage and divider stages
    logic [DIV_STAGES:0] div_vld_reg;
    div_t                div_reg  [DIV_STAGES+1];
    div_t                div_next [DIV_STAGES+1];

    always_comb
    begin
        div_t                 t;
        int                   k;
        logic [TRIAL_W-1:0]   trial;
        div_next[0].used  = pre_reg.used;
        div_next[0].clamp = pre_reg.clamp;
        div_next[0].den   = pre_reg.den;
        div_next[0].rem   = REM_W'(pre_reg.num) * REM_W'(PCT_FULL);
        div_next[0].quot  = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            t = div_reg[s];
            for (int j = 0; j < STEP_PER; j++)
            begin
                k = QUOT_W - 1 - (s * STEP_PER + j);
                if (k >= 0)
                begin
                    trial = TRIAL_W'(t.den) << k;
                    if (TRIAL_W'(t.rem) >= trial)
                    begin
                        t.rem     = t.rem - REM_W'(trial);
                        t.quot[k] = 1'b1;
                    end
                end
            end
            div_next[s+1] = t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
        end
        else
        begin
            div_vld_reg <= {div_vld_reg[DIV_STAGES-1:0], pre_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= DIV_STAGES; s++)
        begin
            div_reg[s] <= div_next[s];
        end
    end

    // output word
    logic             done_reg;
    logic [PCT_W-1:0] pct_reg, pct_next;
    logic             used_reg;
    div_t             last;

    assign last = div_reg[DIV_STAGES];

    always_comb
    begin
        case (last.clamp)
            CLAMP_ZERO: pct_next = '0;
            CLAMP_FULL: pct_next = PCT_FULL;
            default:    pct_next = last.quot;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        pct_reg  <= pct_next;
        used_reg <= last.used;
    end

    assign done             = done_reg;
    assign brake_percent    = pct_reg;
    assign used_calibration = used_reg;
    assign fault_bits       = fault_reg;

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
    import pcbs_pkg::*;

    localparam int unsigned ADC_FULL           = 4095;
    localparam int unsigned MIN_THROTTLE_SPAN  = 200;
    localparam int unsigned MAX_SPAN_RATIO_PCT = 150;
    localparam int unsigned MIN_BRAKE_SPAN     = 100;
    localparam int unsigned PCT_SCALE          = 100;
    localparam int unsigned SAMPLE_MAX         = (1 << SAMPLE_W) - 1;

    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT   = 100000;
    localparam int unsigned RANDOM_WORDS  = 950;
    localparam int unsigned RANDOM_PHASES = 12;

    typedef struct packed {
        logic [PCT_W-1:0]   pct;
        logic [FAULT_W-1:0] faults;
        logic               used;
    } brake_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [SAMPLE_W-1:0] brake_sample = '0;
    logic                cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [REG_W-1:0]    cfg_wr_data = '0;
    logic                done;
    logic [PCT_W-1:0]    brake_percent;
    logic [FAULT_W-1:0]  fault_bits;
    logic                used_calibration;

    logic [REG_W-1:0] cal_regs [NUM_REGS];
    brake_word_t      awaited_words [$];
    int unsigned      errors = 0;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 0;
    bit               gaps_on = 1'b1;

    pedal_calibration_check_and_brake_scale i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .brake_sample     (brake_sample),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .done             (done),
        .brake_percent    (brake_percent),
        .fault_bits       (fault_bits),
        .used_calibration (used_calibration)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        foreach (cal_regs[i])
            cal_regs[i] = '0;
    end

    function automatic logic [FAULT_W-1:0] calib_faults();
        int unsigned t1r, t1f, t2r, t2f, br, ba, bh, bf, s1, s2, lo, hi, bspan;
        logic [FAULT_W-1:0] f;
        t1r = cal_regs[REG_T1_REST[2:0]];
        t1f = cal_regs[REG_T1_FULL[2:0]];
        t2r = cal_regs[REG_T2_REST[2:0]];
        t2f = cal_regs[REG_T2_FULL[2:0]];
        br  = cal_regs[REG_BRAKE_REST[2:0]];
        ba  = cal_regs[REG_BRAKE_ARM[2:0]];
        bh  = cal_regs[REG_BRAKE_HARD[2:0]];
        bf  = cal_regs[REG_BRAKE_FULL[2:0]];
        f = '0;
        foreach (cal_regs[i])
            if (cal_regs[i] > ADC_FULL)
                f[F_RANGE] = 1'b1;
        if (t1f <= t1r || t2f <= t2r)
            f[F_MONO] = 1'b1;
        s1 = (t1f > t1r) ? t1f - t1r : 0;
        s2 = (t2f > t2r) ? t2f - t2r : 0;
        if (s1 < MIN_THROTTLE_SPAN)
            f[F_SPAN1] = 1'b1;
        if (s2 < MIN_THROTTLE_SPAN)
            f[F_SPAN2] = 1'b1;
        if (s1 >= MIN_THROTTLE_SPAN && s2 >= MIN_THROTTLE_SPAN)
        begin
            lo = (s1 > s2) ? s2 : s1;
            hi = (s1 > s2) ? s1 : s2;
            if (lo * MAX_SPAN_RATIO_PCT < hi * PCT_SCALE)
                f[F_RATIO] = 1'b1;
        end
        bspan = (bf > br) ? bf - br : 0;
        if (br != 0 && bspan < MIN_BRAKE_SPAN)
            f[F_BRK_SPAN] = 1'b1;
        if (!(ba < bh && bh < bf) || (br != 0 && br >= ba))
            f[F_BRK_ORDER] = 1'b1;
        return f;
    endfunction

    function automatic brake_word_t scale_brake(input logic [SAMPLE_W-1:0] sample);
        int unsigned raw, br, bf;
        brake_word_t w;
        raw = sample;
        br  = cal_regs[REG_BRAKE_REST[2:0]];
        bf  = cal_regs[REG_BRAKE_FULL[2:0]];
        w.faults = calib_faults();
        if (br != 0 && bf > br)
        begin
            w.used = 1'b1;
            if (raw <= br)
                w.pct = '0;
            else if (raw >= bf)
                w.pct = PCT_FULL;
            else
                w.pct = PCT_W'(((raw - br) * PCT_SCALE) / (bf - br));
        end
        else
        begin
            w.used = 1'b0;
            if (raw >= ADC_FULL)
                w.pct = PCT_FULL;
            else
                w.pct = PCT_W'((raw * PCT_SCALE) / ADC_FULL);
        end
        return w;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // check words leaving the block, then log the word going in and any config write
    always @(posedge clk)
    begin
        brake_word_t want;
        if (done)
        begin
            if (awaited_words.size() == 0)
                note_error($sformatf("unexpected word pct=%0d faults=%0h used=%0b",
                                     brake_percent, fault_bits, used_calibration));
            else
            begin
                want = awaited_words.pop_front();
                if (brake_percent !== want.pct)
                    note_error($sformatf("brake_percent expected %0d got %0d",
                                         want.pct, brake_percent));
                if (fault_bits !== want.faults)
                    note_error($sformatf("fault_bits expected %0h got %0h",
                                         want.faults, fault_bits));
                if (used_calibration !== want.used)
                    note_error($sformatf("used_calibration expected %0b got %0b",
                                         want.used, used_calibration));
            end
        end
        if (rst_n && start && !busy)
            awaited_words.push_back(scale_brake(brake_sample));
        if (rst_n && cfg_wr_en && cfg_index < NUM_REGS)
            cal_regs[cfg_index[2:0]] = cfg_wr_data;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int unsigned gap;
        start <= 1'b1;
        brake_sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 7);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            else
                burst_left--;
        end
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
    endtask

    task automatic apply_calibration(input logic [REG_W-1:0] t1r, t1f, t2r, t2f,
                                     input logic [REG_W-1:0] br, ba, bh, bf,
                                     input bit junk_write);
        drain_pipeline();
        write_reg(REG_T1_REST, t1r);
        write_reg(REG_T1_FULL, t1f);
        write_reg(REG_T2_REST, t2r);
        write_reg(REG_T2_FULL, t2f);
        write_reg(REG_BRAKE_REST, br);
        write_reg(REG_BRAKE_ARM, ba);
        write_reg(REG_BRAKE_HARD, bh);
        write_reg(REG_BRAKE_FULL, bf);
        if (junk_write)
            write_reg(IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1)),
                      REG_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // all registers zero: fallback scale, throttle and order faults
    task automatic test_reset_defaults();
        send_sample(12'd0);
        send_sample(12'd40);
        send_sample(12'd41);
        send_sample(12'd4094);
        send_sample(12'd4095);
    endtask

    task automatic test_good_calibration();
        apply_calibration(16'd300, 16'd3500, 16'd400, 16'd3000,
                          16'd200, 16'd400, 16'd800, 16'd3000, 1'b0);
        send_sample(12'd0);
        send_sample(12'd200);
        send_sample(12'd201);
        send_sample(12'd1600);
        send_sample(12'd2999);
        send_sample(12'd3000);
        send_sample(12'd4095);
    endtask

    task automatic test_fault_flags();
        // every register at max
        apply_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(12'd4095);
        // span ratio, short brake span, rest above arm
        apply_calibration(16'd0, 16'd4095, 16'd1000, 16'd1200,
                          16'd1000, 16'd500, 16'd600, 16'd1050, 1'b0);
        send_sample(12'd1025);
        send_sample(12'd1000);
        // inverted channel 1, short channel 2, no rest point
        apply_calibration(16'd3000, 16'd100, 16'd100, 16'd250,
                          16'd0, 16'd100, 16'd200, 16'd4000, 1'b0);
        send_sample(12'd2048);
        // spans and ratio exactly at limits, hard equal to full
        apply_calibration(16'd0, 16'd200, 16'd0, 16'd300,
                          16'd100, 16'd101, 16'd200, 16'd200, 1'b0);
        send_sample(12'd150);
        send_sample(12'd199);
    endtask

    task automatic test_ignored_index();
        drain_pipeline();
        write_reg(4'd8, 16'hFFFF);
        write_reg(4'd15, 16'hFFFF);
        cfg_wr_en <= 1'b0;
        send_sample(12'd150);
    endtask

    task automatic test_random_traffic();
        logic [REG_W-1:0] r [NUM_REGS];
        int unsigned      per_phase;
        int               center, v;
        per_phase = RANDOM_WORDS / RANDOM_PHASES;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    r[0] = REG_W'($urandom_range(0, 1000));
                    r[1] = REG_W'(r[0] + $urandom_range(150, 3095));
                    r[2] = REG_W'($urandom_range(0, 1000));
                    r[3] = REG_W'(r[2] + $urandom_range(150, 3095));
                    r[4] = ($urandom_range(0, 4) == 0) ? '0
                                                       : REG_W'($urandom_range(1, 600));
                    r[5] = REG_W'(r[4] + $urandom_range(0, 400));
                    r[6] = REG_W'(r[5] + $urandom_range(0, 400));
                    r[7] = REG_W'(r[6] + $urandom_range(0, 2000));
                end
                2:
                    foreach (r[i])
                        r[i] = REG_W'($urandom_range(0, ADC_FULL));
                default:
                    foreach (r[i])
                        case ($urandom_range(0, 4))
                            0: r[i] = '0;
                            1: r[i] = REG_W'(ADC_FULL);
                            2: r[i] = REG_W'(ADC_FULL + 1);
                            3: r[i] = 16'hFFFF;
                            default: r[i] = REG_W'($urandom);
                        endcase
            endcase
            apply_calibration(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7],
                              $urandom_range(0, 1));
            gaps_on = (ph % 4 != 1);
            repeat (per_phase)
            begin
                case ($urandom_range(0, 7))
                    0: center = r[REG_BRAKE_REST[2:0]];
                    1: center = r[REG_BRAKE_FULL[2:0]];
                    2: center = ADC_FULL;
                    default: center = -1;
                endcase
                if (center >= 0)
                begin
                    v = center + int'($urandom_range(0, 4)) - 2;
                    if (v < 0)
                        v = 0;
                    if (v > SAMPLE_MAX)
                        v = SAMPLE_MAX;
                end
                else
                    v = $urandom_range(0, SAMPLE_MAX);
                send_sample(SAMPLE_W'(v));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_good_calibration();
        test_fault_flags();
        test_ignored_index();
        test_random_traffic();
        drain_pipeline();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
